// File: hw/rtl/rbgs_pkg.sv
// shared widths, codes and control types of the red-black smoother
package rbgs_pkg;

    localparam int GRID_POINTS = 4096;
    localparam int ADDR_W      = $clog2(GRID_POINTS);
    localparam int VALUE_W     = 32;
    localparam int SIZE_W      = 5;
    localparam int IDX_W       = 4;
    localparam int NK_W        = 2 * SIZE_W - 1;
    localparam int SWEEP_W     = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int STEP_W      = 4;
    localparam int TAP_W       = 3;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_RUN  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_M  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_N  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_K  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_H2      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_H2  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RELAX   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEPS  = 3'd6;

    // point update steps
    localparam logic [STEP_W-1:0] UPD_MUL0     = 4'd0;
    localparam logic [STEP_W-1:0] UPD_MUL1     = 4'd1;
    localparam logic [STEP_W-1:0] UPD_MUL2     = 4'd2;
    localparam logic [STEP_W-1:0] UPD_SUM      = 4'd3;
    localparam logic [STEP_W-1:0] UPD_DIV_LAST = 4'd9;
    localparam logic [STEP_W-1:0] UPD_WRITE    = 4'd10;

    // residual steps
    localparam logic [STEP_W-1:0] RES_LAP      = 4'd0;
    localparam logic [STEP_W-1:0] RES_MUL      = 4'd1;
    localparam logic [STEP_W-1:0] RES_ADD      = 4'd2;
    localparam logic [STEP_W-1:0] RES_OUT      = 4'd3;

    localparam logic [TAP_W-1:0] TAP_LAST = 3'd7;

    typedef struct packed {
        logic              accept;
        logic              load;
        logic              div_start;
        logic              div_sel;
        logic              set_center;
        logic              center_sel;
        logic [IDX_W-1:0]  ci;
        logic [IDX_W-1:0]  cj;
        logic [IDX_W-1:0]  ck;
        logic              fetch;
        logic [TAP_W-1:0]  tap;
        logic              math;
        logic              resid;
        logic [STEP_W-1:0] step;
        logic              run_result;
    } t_dp_cmd;

    typedef struct packed {
        logic               div_done;
        logic [SIZE_W-1:0]  m;
        logic [SIZE_W-1:0]  n;
        logic [SIZE_W-1:0]  k;
        logic [SWEEP_W-1:0] sweeps;
    } t_dp_stat;

endpackage

// File: hw/rtl/red_black_gauss_seidel_smoother.sv
// top level of the red-black gauss-seidel smoother
//
// items are issued on start while busy is low; op selects load, run or read, and OP_NONE does nothing.
// load writes u and f at point_index in the accepting edge, busy stays low,
// and no result follows.
// read decodes the index with a shared 12-step divider (twice), gathers
// the center and six neighbors from the u store one per cycle, then forms
// the residual; the result strobe o_valid is high in state S_OUT.
// run walks every interior point of each color for sweep_count sweep pairs:
// points of the other color are only scanned; each updated point gathers
// the center and neighbors on the single u read port, then runs 11 arithmetic
// steps including a byte-serial divide by three; o_valid with o_run_done
// high closes the run.
// each result is shown for exactly one cycle; the receiver cannot stall.
// configuration beats are always taken (o_cfg_ready high) and should only
// be issued while busy is low.
// reset restores the register defaults; grid contents are undefined until
// loaded.
module red_black_gauss_seidel_smoother (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [1:0]                            i_op,
    input  logic [rbgs_pkg::ADDR_W-1:0]           i_point_index,
    input  logic signed [rbgs_pkg::VALUE_W-1:0]   i_solution_in,
    input  logic signed [rbgs_pkg::VALUE_W-1:0]   i_source_in,
    output logic                                  o_valid,
    output logic signed [rbgs_pkg::VALUE_W-1:0]   o_solution_out,
    output logic signed [rbgs_pkg::VALUE_W-1:0]   o_residual_out,
    output logic                                  o_run_done,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [rbgs_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [rbgs_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import rbgs_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    rbgs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (i_op),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    rbgs_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_point_index  (i_point_index),
        .i_solution_in  (i_solution_in),
        .i_source_in    (i_source_in),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_solution_out (o_solution_out),
        .o_residual_out (o_residual_out),
        .o_run_done     (o_run_done)
    );

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result beat outside a busy item");

    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid && !busy)
        else $error("more than one result beat per item");

    a_run_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_run_done |-> o_solution_out == '0 && o_residual_out == '0)
        else $error("run result carries data");
endmodule

// File: hw/rtl/rbgs_ram.sv
// generic simple dual-port ram with registered read
module rbgs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: hw/rtl/rbgs_div.sv
// iterative restoring divider for index decoding
module rbgs_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rbgs_pkg::ADDR_W-1:0] i_dividend,
    input  logic [rbgs_pkg::NK_W-1:0]   i_divisor,
    output logic                       o_done,
    output logic [rbgs_pkg::ADDR_W-1:0] o_quotient,
    output logic [rbgs_pkg::NK_W-1:0]   o_remainder
);
    import rbgs_pkg::*;

    localparam int CNT_W = $clog2(ADDR_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [ADDR_W-1:0] r_quo;
    logic [NK_W-1:0]   r_rem;
    logic [NK_W-1:0]   r_dvs;
    logic [NK_W:0]     trial;
    logic              fits;

    assign trial = {r_rem, r_quo[ADDR_W-1]};
    assign fits  = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ADDR_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[ADDR_W-2:0], fits};
            r_rem <= fits ? NK_W'(trial - {1'b0, r_dvs}) : trial[NK_W-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;
endmodule

// File: hw/rtl/rbgs_datapath.sv
// grid stores, configuration registers and update / residual arithmetic
module rbgs_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rbgs_pkg::t_dp_cmd                 i_cmd,
    output rbgs_pkg::t_dp_stat                o_stat,
    input  logic [rbgs_pkg::ADDR_W-1:0]       i_point_index,
    input  logic signed [rbgs_pkg::VALUE_W-1:0] i_solution_in,
    input  logic signed [rbgs_pkg::VALUE_W-1:0] i_source_in,
    input  logic                              i_cfg_we,
    input  logic [rbgs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rbgs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic signed [rbgs_pkg::VALUE_W-1:0] o_solution_out,
    output logic signed [rbgs_pkg::VALUE_W-1:0] o_residual_out,
    output logic                              o_run_done
);
    import rbgs_pkg::*;

    localparam logic [47:0]        DIV_BIAS   = 48'd3 << 39;
    localparam logic signed [55:0] DIV_OFFSET = 56'sd1 << 39;

    function automatic logic [SIZE_W-1:0] side(input logic [SIZE_W-1:0] r);
        if (r < SIZE_W'(3)) return SIZE_W'(3);
        if (r > SIZE_W'(16)) return SIZE_W'(16);
        return r;
    endfunction

    function automatic logic signed [VALUE_W-1:0] sat32(input logic signed [55:0] v);
        if (v > 56'sd2147483647) return 32'sh7fffffff;
        if (v < -56'sd2147483648) return 32'sh80000000;
        return VALUE_W'(v);
    endfunction

    // one byte of a divide by three, msb first
    function automatic logic [9:0] div3_byte(input logic [1:0] rm, input logic [7:0] din);
        logic [1:0] r;
        logic [2:0] t;
        logic [7:0] q;
        r = rm;
        q = '0;
        for (int b = 7; b >= 0; b--) begin
            t = {r, din[b]};
            if (t >= 3'd3) begin
                q[b] = 1'b1;
                r = 2'(t - 3'd3);
            end else begin
                r = t[1:0];
            end
        end
        return {r, q};
    endfunction

    // configuration
    logic [SIZE_W-1:0]  r_size_m, r_size_n, r_size_k;
    logic [16:0]        r_h2;
    logic [31:0]        r_inv;
    logic [15:0]        r_w;
    logic [SWEEP_W-1:0] r_sweeps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_m <= SIZE_W'(16);
            r_size_n <= SIZE_W'(16);
            r_size_k <= SIZE_W'(16);
            r_h2     <= 17'd284;
            r_inv    <= 32'd14745600;
            r_w      <= 16'd16384;
            r_sweeps <= 8'd16;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SIZE_M: r_size_m <= i_cfg_data[SIZE_W-1:0];
                CFG_SIZE_N: r_size_n <= i_cfg_data[SIZE_W-1:0];
                CFG_SIZE_K: r_size_k <= i_cfg_data[SIZE_W-1:0];
                CFG_H2:     r_h2     <= i_cfg_data[16:0];
                CFG_INV_H2: r_inv    <= i_cfg_data;
                CFG_RELAX:  r_w      <= i_cfg_data[15:0];
                CFG_SWEEPS: r_sweeps <= i_cfg_data[SWEEP_W-1:0];
                default: ;
            endcase
        end
    end

    logic [SIZE_W-1:0] m, n, k;
    logic [NK_W-1:0]   nk;

    assign m  = side(r_size_m);
    assign n  = side(r_size_n);
    assign k  = side(r_size_k);
    assign nk = NK_W'(n) * NK_W'(k);

    // index decode
    logic              div_done;
    logic [ADDR_W-1:0] div_quo;
    logic [NK_W-1:0]   div_rem;
    logic [ADDR_W-1:0] div_dividend;
    logic [NK_W-1:0]   div_divisor;
    logic              r_div_sel;
    logic [ADDR_W-1:0] r_pi;
    logic [ADDR_W-1:0] r_di, r_dj;
    logic [NK_W-1:0]   r_dk;

    assign div_dividend = i_cmd.div_sel ? ADDR_W'(div_rem) : r_pi;
    assign div_divisor  = i_cmd.div_sel ? NK_W'(k) : nk;

    rbgs_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pi <= i_point_index;
        end
        if (i_cmd.div_start) begin
            r_div_sel <= i_cmd.div_sel;
        end
        if (div_done) begin
            if (r_div_sel) begin
                r_dj <= div_quo;
                r_dk <= div_rem;
            end else begin
                r_di <= div_quo;
            end
        end
    end

    logic interior;
    assign interior = (r_di != '0) && (13'(r_di) + 13'd1 < 13'(m))
                   && (r_dj != '0) && (13'(r_dj) + 13'd1 < 13'(n))
                   && (r_dk != '0) && (10'(r_dk) + 10'd1 < 10'(k));

    // grid stores
    logic [ADDR_W-1:0]         r_c;
    logic [ADDR_W-1:0]         center;
    logic [ADDR_W-1:0]         u_raddr;
    logic [ADDR_W-1:0]         u_waddr;
    logic [VALUE_W-1:0]        u_wdata;
    logic                      u_we;
    logic signed [VALUE_W-1:0] u_rdata;
    logic signed [VALUE_W-1:0] f_rdata;
    logic signed [VALUE_W-1:0] upd_value;

    assign center = i_cmd.center_sel ? r_pi
        : ADDR_W'((15'(i_cmd.ci) * 15'(n) + 15'(i_cmd.cj)) * 15'(k) + 15'(i_cmd.ck));

    always_comb begin
        unique case (i_cmd.tap)
            3'd1:    u_raddr = r_c - ADDR_W'(1);
            3'd2:    u_raddr = r_c + ADDR_W'(1);
            3'd3:    u_raddr = r_c - ADDR_W'(k);
            3'd4:    u_raddr = r_c + ADDR_W'(k);
            3'd5:    u_raddr = r_c - ADDR_W'(nk);
            3'd6:    u_raddr = r_c + ADDR_W'(nk);
            default: u_raddr = r_c;
        endcase
    end

    assign u_we    = i_cmd.load
                  || (i_cmd.math && !i_cmd.resid && i_cmd.step == UPD_WRITE);
    assign u_waddr = i_cmd.load ? i_point_index : r_c;
    assign u_wdata = i_cmd.load ? i_solution_in : upd_value;

    rbgs_ram #(.WIDTH(VALUE_W), .DEPTH(GRID_POINTS)) u_solution_ram (
        .i_clk   (i_clk),
        .i_we    (u_we),
        .i_waddr (u_waddr),
        .i_wdata (u_wdata),
        .i_raddr (u_raddr),
        .o_rdata (u_rdata)
    );

    rbgs_ram #(.WIDTH(VALUE_W), .DEPTH(GRID_POINTS)) u_source_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load),
        .i_waddr (i_point_index),
        .i_wdata (i_source_in),
        .i_raddr (r_c),
        .o_rdata (f_rdata)
    );

    // neighbor gather
    logic signed [VALUE_W-1:0] r_u, r_f;
    logic signed [34:0]        r_sum;

    always_ff @(posedge i_clk) begin
        if (i_cmd.set_center) begin
            r_c <= center;
        end
        if (i_cmd.fetch) begin
            if (i_cmd.tap == '0) begin
                r_sum <= '0;
            end else if (i_cmd.tap == 3'd1) begin
                r_u <= u_rdata;
                r_f <= f_rdata;
            end else begin
                r_sum <= r_sum + 35'(u_rdata);
            end
        end
    end

    // arithmetic
    logic signed [17:0] relax_c;
    logic signed [19:0] c6_next;
    logic signed [35:0] u36;
    logic signed [55:0] num;
    logic signed [55:0] y;
    logic [9:0]         d3;

    logic signed [49:0] r_p0;
    logic signed [19:0] r_c6;
    logic signed [35:0] r_s;
    logic signed [51:0] r_pc;
    logic signed [52:0] r_pw;
    logic [47:0]        r_dv;
    logic [47:0]        r_qt;
    logic [1:0]         r_rm;
    logic signed [35:0] r_lap;
    logic signed [52:0] r_pa, r_pb;
    logic signed [55:0] r_q;

    assign relax_c   = 18'sd16384 - $signed({2'b00, r_w});
    assign c6_next   = (20'(relax_c) <<< 2) + (20'(relax_c) <<< 1);
    assign u36       = 36'(r_u);
    assign num       = 56'(r_pw) + 56'(r_pc) + 56'sd49152;
    assign y         = num >>> 15;
    assign d3        = div3_byte(r_rm, r_dv[47:40]);
    assign upd_value = sat32($signed({8'd0, r_qt}) - DIV_OFFSET);

    always_ff @(posedge i_clk) begin
        if (i_cmd.math && !i_cmd.resid) begin
            unique case (i_cmd.step)
                UPD_MUL0: begin
                    r_p0 <= $signed({1'b0, r_h2}) * r_f;
                    r_c6 <= c6_next;
                end
                UPD_MUL1: begin
                    r_s  <= 36'(r_sum) - 36'((r_p0 + 50'sd32768) >>> 16);
                    r_pc <= r_c6 * r_u;
                end
                UPD_MUL2: begin
                    r_pw <= r_s * $signed({1'b0, r_w});
                end
                UPD_SUM: begin
                    r_dv <= 48'(y) + DIV_BIAS;
                    r_rm <= '0;
                end
                default: begin
                    if (i_cmd.step <= UPD_DIV_LAST) begin
                        r_dv <= r_dv << 8;
                        r_rm <= d3[9:8];
                        r_qt <= {r_qt[39:0], d3[7:0]};
                    end
                end
            endcase
        end
        if (i_cmd.math && i_cmd.resid) begin
            unique case (i_cmd.step)
                RES_LAP: r_lap <= 36'(r_sum) - ((u36 <<< 2) + (u36 <<< 1));
                RES_MUL: begin
                    r_pa <= r_lap * $signed({1'b0, r_inv[31:16]});
                    r_pb <= r_lap * $signed({1'b0, r_inv[15:0]});
                end
                RES_ADD: r_q <= 56'(r_pa) + 56'((r_pb + 53'sd32768) >>> 16);
                default: ;
            endcase
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.run_result) begin
            o_solution_out <= '0;
            o_residual_out <= '0;
            o_run_done     <= 1'b1;
        end else if (i_cmd.math && i_cmd.resid && i_cmd.step == RES_OUT) begin
            o_solution_out <= r_u;
            o_residual_out <= interior ? sat32(56'(r_f) - r_q) : '0;
            o_run_done     <= 1'b0;
        end
    end

    assign o_stat.div_done = div_done;
    assign o_stat.m        = m;
    assign o_stat.n        = n;
    assign o_stat.k        = k;
    assign o_stat.sweeps   = r_sweeps;
endmodule

// File: hw/rtl/rbgs_ctrl.sv
// sequencing state machine: sweep walk, neighbor fetch and arithmetic steps
module rbgs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [1:0]         i_op,
    input  rbgs_pkg::t_dp_stat i_stat,
    output rbgs_pkg::t_dp_cmd  o_cmd,
    output logic               o_busy,
    output logic               o_valid
);
    import rbgs_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_DEC   = 8'b0000_0010,
        S_DIV_I = 8'b0000_0100,
        S_DIV_J = 8'b0000_1000,
        S_SCAN  = 8'b0001_0000,
        S_FETCH = 8'b0010_0000,
        S_MATH  = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_i, n_i, r_j, n_j, r_k, n_k;
    logic               r_phase, n_phase;
    logic [SWEEP_W-1:0] r_sweep, n_sweep;
    logic [TAP_W-1:0]   r_tap, n_tap;
    logic [STEP_W-1:0]  r_step, n_step;
    logic               r_resid, n_resid;

    logic k_last, j_last, i_last, sweep_last, match, accept;

    assign k_last     = (SIZE_W'(r_k) + SIZE_W'(2)) == i_stat.k;
    assign j_last     = (SIZE_W'(r_j) + SIZE_W'(2)) == i_stat.n;
    assign i_last     = (SIZE_W'(r_i) + SIZE_W'(2)) == i_stat.m;
    assign sweep_last = (r_sweep + 1'b1) == i_stat.sweeps;
    assign match      = (r_i[0] ^ r_j[0] ^ r_k[0]) == r_phase;
    assign accept     = i_start && (r_state == S_IDLE);

    always_comb begin
        logic advance;
        advance  = 1'b0;
        n_state  = r_state;
        n_i      = r_i;
        n_j      = r_j;
        n_k      = r_k;
        n_phase  = r_phase;
        n_sweep  = r_sweep;
        n_tap    = r_tap;
        n_step   = r_step;
        n_resid  = r_resid;
        o_cmd    = '0;
        o_cmd.ci = r_i;
        o_cmd.cj = r_j;
        o_cmd.ck = r_k;
        o_cmd.tap   = r_tap;
        o_cmd.step  = r_step;
        o_cmd.resid = r_resid;

        unique case (r_state)
            S_IDLE: begin
                o_cmd.accept = accept;
                if (accept) begin
                    priority if (i_op == OP_LOAD) begin
                        o_cmd.load = 1'b1;
                    end else if (i_op == OP_RUN) begin
                        n_i     = IDX_W'(1);
                        n_j     = IDX_W'(1);
                        n_k     = IDX_W'(1);
                        n_phase = 1'b0;
                        n_sweep = '0;
                        n_resid = 1'b0;
                        if (i_stat.sweeps == '0) begin
                            o_cmd.run_result = 1'b1;
                            n_state = S_OUT;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else if (i_op == OP_READ) begin
                        n_resid = 1'b1;
                        n_state = S_DEC;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_DEC: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIV_I;
            end
            S_DIV_I: begin
                if (i_stat.div_done) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = 1'b1;
                    n_state = S_DIV_J;
                end
            end
            S_DIV_J: begin
                if (i_stat.div_done) begin
                    o_cmd.set_center = 1'b1;
                    o_cmd.center_sel = 1'b1;
                    n_tap   = '0;
                    n_state = S_FETCH;
                end
            end
            S_SCAN: begin
                if (match) begin
                    o_cmd.set_center = 1'b1;
                    n_tap   = '0;
                    n_state = S_FETCH;
                end else begin
                    advance = 1'b1;
                end
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_tap = r_tap + 1'b1;
                if (r_tap == TAP_LAST) begin
                    n_step  = '0;
                    n_state = S_MATH;
                end
            end
            S_MATH: begin
                o_cmd.math = 1'b1;
                n_step = r_step + 1'b1;
                if (r_resid && r_step == RES_OUT) begin
                    n_state = S_OUT;
                end else if (!r_resid && r_step == UPD_WRITE) begin
                    advance = 1'b1;
                end
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        if (advance) begin
            n_state = S_SCAN;
            if (!k_last) begin
                n_k = r_k + 1'b1;
            end else begin
                n_k = IDX_W'(1);
                if (!j_last) begin
                    n_j = r_j + 1'b1;
                end else begin
                    n_j = IDX_W'(1);
                    if (!i_last) begin
                        n_i = r_i + 1'b1;
                    end else begin
                        n_i = IDX_W'(1);
                        n_phase = !r_phase;
                        if (r_phase) begin
                            n_sweep = r_sweep + 1'b1;
                            if (sweep_last) begin
                                o_cmd.run_result = 1'b1;
                                n_state = S_OUT;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_phase <= 1'b0;
            r_sweep <= '0;
            r_tap   <= '0;
            r_step  <= '0;
            r_resid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            r_phase <= n_phase;
            r_sweep <= n_sweep;
            r_tap   <= n_tap;
            r_step  <= n_step;
            r_resid <= n_resid;
        end
    end

    assign o_busy  = r_state != S_IDLE;
    assign o_valid = r_state == S_OUT;
endmodule

// File: sim/red_black_gauss_seidel_smoother_test.sv
// testbench for the red-black gauss-seidel smoother: random items checked against a predictor
`timescale 1ns / 1ps

module red_black_gauss_seidel_smoother_test;
    import rbgs_pkg::*;

    typedef struct {
        logic signed [VALUE_W-1:0] sol;
        logic signed [VALUE_W-1:0] res;
        logic                      done;
    } t_answer;

    class smoother_scoreboard;
        longint    u_grid[GRID_POINTS];
        longint    f_grid[GRID_POINTS];
        bit [4:0]  size_m, size_n, size_k;
        bit [16:0] h2;
        bit [31:0] inv_h2;
        bit [15:0] relax;
        bit [7:0]  sweeps;
        t_answer   answers[$];
        int        errors;

        function new();
            size_m = 16;
            size_n = 16;
            size_k = 16;
            h2     = 284;
            inv_h2 = 32'd14745600;
            relax  = 16384;
            sweeps = 16;
            errors = 0;
        endfunction

        function void report(string what, longint got, longint want);
            $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
            errors++;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SIZE_M: size_m = data[4:0];
                CFG_SIZE_N: size_n = data[4:0];
                CFG_SIZE_K: size_k = data[4:0];
                CFG_H2:     h2     = data[16:0];
                CFG_INV_H2: inv_h2 = data;
                CFG_RELAX:  relax  = data[15:0];
                CFG_SWEEPS: sweeps = data[7:0];
                default: ;
            endcase
        endfunction

        function longint floor_div(longint a, longint d);
            if (a >= 0) return a / d;
            return -((-a + d - 1) / d);
        endfunction

        function longint sat(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function int side(bit [4:0] r);
            if (r < 3) return 3;
            if (r > 16) return 16;
            return r;
        endfunction

        function int addr(int i, int j, int k, int n, int kk);
            return ((i * n + j) * kk + k) % GRID_POINTS;
        endfunction

        function longint around(int i, int j, int k, int n, int kk);
            return u_grid[addr(i, j, k - 1, n, kk)] + u_grid[addr(i, j, k + 1, n, kk)]
                 + u_grid[addr(i, j - 1, k, n, kk)] + u_grid[addr(i, j + 1, k, n, kk)]
                 + u_grid[addr(i - 1, j, k, n, kk)] + u_grid[addr(i + 1, j, k, n, kk)];
        endfunction

        function void color_pass(int color, int m, int n, int kk);
            int     c;
            longint s, num;
            for (int i = 1; i + 1 < m; i++)
                for (int j = 1; j + 1 < n; j++)
                    for (int k = 1; k + 1 < kk; k++) begin
                        if (((i + j + k) & 1) != color) continue;
                        c   = addr(i, j, k, n, kk);
                        s   = around(i, j, k, n, kk)
                            - floor_div(longint'(h2) * f_grid[c] + 32768, 65536);
                        num = s * longint'(relax)
                            + 6 * (16384 - longint'(relax)) * u_grid[c];
                        u_grid[c] = sat(floor_div(num + 49152, 98304));
                    end
        endfunction

        function longint point_residual(int i, int j, int k, int n, int kk);
            int     c;
            longint lap, q;
            c   = addr(i, j, k, n, kk);
            lap = around(i, j, k, n, kk) - 6 * u_grid[c];
            q   = lap * longint'(inv_h2[31:16])
                + floor_div(lap * longint'(inv_h2[15:0]) + 32768, 65536);
            return sat(f_grid[c] - q);
        endfunction

        function void note_item(logic [1:0] op, logic [ADDR_W-1:0] pi,
                                logic signed [VALUE_W-1:0] u, logic signed [VALUE_W-1:0] f);
            int      m, n, kk, i, j, k;
            t_answer a;
            m  = side(size_m);
            n  = side(size_n);
            kk = side(size_k);
            case (op)
                OP_LOAD: begin
                    u_grid[pi] = u;
                    f_grid[pi] = f;
                end
                OP_RUN: begin
                    for (int s = 0; s < sweeps; s++) begin
                        color_pass(0, m, n, kk);
                        color_pass(1, m, n, kk);
                    end
                    a.sol  = 0;
                    a.res  = 0;
                    a.done = 1;
                    answers.insert(answers.size(), a);
                end
                OP_READ: begin
                    k      = pi % kk;
                    j      = (pi / kk) % n;
                    i      = pi / (kk * n);
                    a.sol  = u_grid[pi];
                    a.res  = 0;
                    a.done = 0;
                    if (i >= 1 && i + 1 < m && j >= 1 && j + 1 < n && k >= 1 && k + 1 < kk)
                        a.res = point_residual(i, j, k, n, kk);
                    answers.insert(answers.size(), a);
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic signed [VALUE_W-1:0] sol,
                                   logic signed [VALUE_W-1:0] res, logic done);
            t_answer a;
            if (answers.size() == 0) begin
                report("unexpected result", done, 0);
                return;
            end
            a = answers.pop_front();
            if (sol !== a.sol) report("solution_out", sol, a.sol);
            if (res !== a.res) report("residual_out", res, a.res);
            if (done !== a.done) report("run_done", done, a.done);
        endfunction
    endclass

    localparam int LOADED = 256;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic [1:0]                i_op;
    logic [ADDR_W-1:0]         i_point_index;
    logic signed [VALUE_W-1:0] i_solution_in;
    logic signed [VALUE_W-1:0] i_source_in;
    logic                      o_valid;
    logic signed [VALUE_W-1:0] o_solution_out;
    logic signed [VALUE_W-1:0] o_residual_out;
    logic                      o_run_done;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index;
    logic [CFG_DATA_W-1:0]     i_cfg_data;

    smoother_scoreboard grid_sb;
    int                 burst_left;

    red_black_gauss_seidel_smoother i_dut (.*);

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #50ms;
        $display("CHECKS FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            grid_sb.check_result(o_solution_out, o_residual_out, o_run_done);
    end

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom;
            default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        endcase
    endfunction

    task automatic send_item(logic [1:0] op, logic [ADDR_W-1:0] pi,
                             logic [VALUE_W-1:0] u, logic [VALUE_W-1:0] f);
        start         <= 1'b1;
        i_op          <= op;
        i_point_index <= pi;
        i_solution_in <= u;
        i_source_in   <= f;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        grid_sb.note_item(op, pi, u, f);
    endtask

    // bursts of random length between random gaps
    task automatic pace();
        if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                       : $urandom_range(0, 8);
        end else begin
            burst_left--;
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (grid_sb.answers.size() != 0 || busy) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        grid_sb.write_reg(idx, data);
        i_cfg_valid <= 1'b0;
    endtask

    // reads stay inside the loaded part of the store
    task automatic random_items(int count, int run_pct);
        int                roll;
        logic [1:0]        op;
        logic [ADDR_W-1:0] pi;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < run_pct) op = OP_RUN;
            else if (roll < run_pct + 30) op = OP_LOAD;
            else if (roll < run_pct + 33) op = OP_NONE;
            else op = OP_READ;
            if (op == OP_READ) pi = ADDR_W'($urandom_range(0, LOADED - 1));
            else pi = ADDR_W'($urandom);
            send_item(op, pi, pick_value(), pick_value());
            pace();
        end
    endtask

    // phase settings: m, n, k, h2, inv_h2, relax, sweeps, run share
    int unsigned ph_m[6]      = '{3, 31, 4, 5, 6, 0};
    int unsigned ph_n[6]      = '{3, 2, 5, 4, 5, 1};
    int unsigned ph_k[6]      = '{3, 3, 6, 3, 4, 2};
    int unsigned ph_h2[6]     = '{0, 284, 131071, 65536, 284, 1000};
    int unsigned ph_inv[6]    = '{0, 14745600, 32'hffffffff, 14745600, 65536, 123456789};
    int unsigned ph_relax[6]  = '{0, 16384, 65535, 32768, 16384, 20000};
    int unsigned ph_sweeps[6] = '{255, 1, 2, 0, 3, 1};
    int unsigned ph_runs[6]   = '{2, 6, 6, 10, 5, 8};

    initial begin
        grid_sb       = new();
        burst_left    = 0;
        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_op          <= OP_LOAD;
        i_point_index <= '0;
        i_solution_in <= '0;
        i_source_in   <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_SIZE_M;
        i_cfg_data    <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // every entry that a read or a sweep can touch is loaded first
        for (int p = 0; p < LOADED; p++) begin
            send_item(OP_LOAD, ADDR_W'(p), pick_value(), pick_value());
            pace();
        end
        settle();
        write_cfg(CFG_SIZE_M, 4);
        write_cfg(CFG_SIZE_N, 8);
        write_cfg(CFG_SIZE_K, 8);
        write_cfg(CFG_SWEEPS, 1);

        send_item(OP_READ, 12'd0, '0, '0);
        send_item(OP_READ, 12'd100, '0, '0);
        send_item(OP_LOAD, 12'd255, 32'h7fffffff, 32'h80000000);
        send_item(OP_READ, 12'd255, '0, '0);
        send_item(OP_LOAD, 12'd100, 32'h80000000, 32'h7fffffff);
        send_item(OP_READ, 12'd100, '0, '0);
        send_item(OP_READ, 12'd101, '0, '0);
        send_item(OP_NONE, 12'd7, 32'h1, 32'h1);
        send_item(OP_LOAD, 12'd100, 32'h0001_0000, 32'hffff_0000);
        send_item(OP_RUN, 12'd0, '0, '0);
        send_item(OP_READ, 12'd100, '0, '0);
        send_item(OP_READ, 12'd155, '0, '0);
        send_item(OP_READ, 12'd254, '0, '0);
        start <= 1'b0;

        for (int ph = 0; ph < 6; ph++) begin
            settle();
            write_cfg(CFG_SIZE_M, ph_m[ph]);
            write_cfg(CFG_SIZE_N, ph_n[ph]);
            write_cfg(CFG_SIZE_K, ph_k[ph]);
            write_cfg(CFG_H2, ph_h2[ph]);
            write_cfg(CFG_INV_H2, ph_inv[ph]);
            write_cfg(CFG_RELAX, ph_relax[ph]);
            write_cfg(CFG_SWEEPS, ph_sweeps[ph]);
            send_item(OP_RUN, ADDR_W'($urandom), $urandom, $urandom);
            random_items(180, ph_runs[ph]);
        end

        settle();
        if (grid_sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
